// ===== rtl/ffaa_pkg.sv =====
// shared types, constants and codes of the first-fit arena allocator
package ffaa_pkg;

  // field and key widths
  localparam int FIELD_W = 22;
  localparam int KEY_W   = FIELD_W + 1;
  localparam int SUM_W   = FIELD_W + 2;

  // arena geometry
  localparam int ARENA_BYTES    = 4194304;
  localparam int HEADER_BYTES   = 24;
  localparam int ALIGN_BYTES    = 8;
  localparam int FREE_SLOTS_DEF = 64;
  localparam int LIVE_SLOTS_DEF = 64;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OOM      = 2'd1,
    STAT_NOT_LIVE = 2'd2,
    STAT_FULL     = 2'd3
  } stat_t;

  // input and result words
  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] user_offset;
  } in_word_t;

  typedef struct packed {
    stat_t              status;
    logic [FIELD_W-1:0] granted_offset;
    logic [FIELD_W-1:0] granted_size;
    logic [1:0]         merges;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] size;
  } ent_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic live;
    logic found;
    logic hit_valid;
    ent_t hit;
    logic prev_valid;
    ent_t prev;
  } tok_t;

  // update broadcast to all cells of one chain
  typedef struct packed {
    logic load_hit;
    logic load_prev;
    logic shift_left;
    logic shift_right;
    ent_t data;
  } cmd_t;

  // per-cell match test
  typedef enum logic [1:0] {
    M_FIT,
    M_ABOVE,
    M_EQUAL,
    M_EMPTY
  } match_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  localparam ent_t FREE_RESET = '{start: '0, size: FIELD_W'(ARENA_BYTES - HEADER_BYTES)};

endpackage

// ===== rtl/first_fit_arena_allocator.sv =====
// top level: free-extent and live-block cell chains with their controller
//
//   channel | ports                          | word
//   input   | in_valid in_stall in_word      | opcode request_size user_offset
//   result  | out_valid out_stall out_word   | status granted_offset granted_size merges
//
// from accept to result, the search token walks one cell per cycle down each chain,
// and the result waits for the token of the longer chain.
// one item is in work at a time; the next is accepted while a result waits.
// a stalled result holds the update of the following item until it is taken.
// synchronous active-low reset leaves one free extent spanning the arena.
module first_fit_arena_allocator
  import ffaa_pkg::*;
#(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int LIVE_SLOTS = LIVE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int LCW = $clog2(LIVE_SLOTS + 1);
  localparam logic [KEY_W-1:0] HDR_K    = KEY_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] HDR_S    = SUM_W'(HEADER_BYTES);
  localparam logic [KEY_W-1:0] ALIGN_M  = KEY_W'(ALIGN_BYTES - 1);

  state_t    state_r, state_nxt;
  in_word_t  req_r;
  logic [FCW-1:0] free_count_r, free_count_nxt;
  logic [LCW-1:0] live_count_r, live_count_nxt;
  logic      launch_r, fdone_r, ldone_r;
  tok_t      fres_r, lres_r;
  logic      out_valid_r;
  out_word_t out_word_r, dec_word;
  logic      accept, apply_go;
  cmd_t      fcmd, lcmd, fdec, ldec;

  tok_t   ftok [FREE_SLOTS+1];
  tok_t   ltok [LIVE_SLOTS+1];
  ent_t   fent [FREE_SLOTS];
  ent_t   lent [LIVE_SLOTS];
  logic   fbef [FREE_SLOTS];
  logic   lbef [LIVE_SLOTS];

  match_t           fmode, lmode;
  logic [KEY_W-1:0] fkey, lkey;
  logic [KEY_W-1:0] size_k, needed_k, rem_k;
  logic [FIELD_W-1:0] hdr_f;
  logic [SUM_W-1:0] prev_end, next_end;
  logic prev_adj, next_adj;

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (fdone_r && ldone_r) state_nxt = ST_APPLY;
      ST_APPLY: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_stall = 1'b1;
    apply_go = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  in_stall = 1'b1;
      ST_APPLY: apply_go = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // search setup for both chains
  assign size_k   = ({1'b0, req_r.request_size} + ALIGN_M) & ~ALIGN_M;
  assign needed_k = size_k + HDR_K;
  assign hdr_f    = req_r.user_offset - FIELD_W'(HEADER_BYTES);

  always_comb begin
    if (req_r.opcode == OP_ALLOC) begin
      fmode = M_FIT;
      fkey  = needed_k;
      lmode = M_EMPTY;
    end else begin
      fmode = M_ABOVE;
      fkey  = {1'b0, hdr_f};
      lmode = M_EQUAL;
    end
    lkey = {1'b0, req_r.user_offset};
  end

  // token launch
  always_comb begin
    ftok[0]      = '0;
    ftok[0].live = launch_r;
    ltok[0]      = '0;
    ltok[0].live = launch_r;
  end

  // free-extent chain
  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_free
    ent_t left_e, right_e;
    logic nb;
    if (k == 0) begin : g_l0
      assign left_e = '0;
    end else begin : g_l
      assign left_e = fent[k-1];
    end
    if (k == FREE_SLOTS - 1) begin : g_rl
      assign right_e = '0;
      assign nb      = 1'b0;
    end else begin : g_r
      assign right_e = fent[k+1];
      assign nb      = fbef[k+1];
    end
    ffaa_cell #(
      .RST_ENT((k == 0) ? FREE_RESET : ent_t'('0))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .valid      (free_count_r > FCW'(k)),
      .mode       (fmode),
      .key        (fkey),
      .tok_in     (ftok[k]),
      .tok_out    (ftok[k+1]),
      .left_ent   (left_e),
      .right_ent  (right_e),
      .next_before(nb),
      .ent        (fent[k]),
      .prev_flag  (fbef[k]),
      .cmd        (fcmd)
    );
  end

  // live-block chain
  for (genvar k = 0; k < LIVE_SLOTS; k++) begin : g_live
    ent_t left_e, right_e;
    logic nb;
    if (k == 0) begin : g_l0
      assign left_e = '0;
    end else begin : g_l
      assign left_e = lent[k-1];
    end
    if (k == LIVE_SLOTS - 1) begin : g_rl
      assign right_e = '0;
      assign nb      = 1'b0;
    end else begin : g_r
      assign right_e = lent[k+1];
      assign nb      = lbef[k+1];
    end
    ffaa_cell #(
      .RST_ENT(ent_t'('0))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .valid      (live_count_r > LCW'(k)),
      .mode       (lmode),
      .key        (lkey),
      .tok_in     (ltok[k]),
      .tok_out    (ltok[k+1]),
      .left_ent   (left_e),
      .right_ent  (right_e),
      .next_before(nb),
      .ent        (lent[k]),
      .prev_flag  (lbef[k]),
      .cmd        (lcmd)
    );
  end

  // adjacency of the freed block to its neighbors
  assign rem_k    = {1'b0, fres_r.hit.size} - needed_k;
  assign prev_end = {2'b0, fres_r.prev.start} + HDR_S + {2'b0, fres_r.prev.size};
  assign next_end = {2'b0, hdr_f} + HDR_S + {2'b0, lres_r.hit.size};
  assign prev_adj = fres_r.prev_valid && (prev_end >= {2'b0, hdr_f});
  assign next_adj = fres_r.found && fres_r.hit_valid && (next_end >= {2'b0, fres_r.hit.start});

  // decision once both tokens are back
  always_comb begin
    dec_word       = '0;
    dec_word.status = STAT_OK;
    fdec           = '0;
    ldec           = '0;
    free_count_nxt = free_count_r;
    live_count_nxt = live_count_r;
    if (req_r.opcode == OP_ALLOC) begin
      if (!fres_r.found) begin
        dec_word.status = STAT_OOM;
      end else if (!lres_r.found) begin
        dec_word.status = STAT_FULL;
      end else begin
        if (rem_k <= HDR_K) begin
          fdec.shift_left         = 1'b1;
          free_count_nxt          = free_count_r - FCW'(1);
          dec_word.granted_size   = fres_r.hit.size;
        end else begin
          fdec.load_hit           = 1'b1;
          fdec.data.start         = fres_r.hit.start + needed_k[FIELD_W-1:0];
          fdec.data.size          = rem_k[FIELD_W-1:0];
          dec_word.granted_size   = size_k[FIELD_W-1:0];
        end
        dec_word.granted_offset = fres_r.hit.start + FIELD_W'(HEADER_BYTES);
        ldec.load_hit           = 1'b1;
        ldec.data.start         = dec_word.granted_offset;
        ldec.data.size          = dec_word.granted_size;
        live_count_nxt          = live_count_r + LCW'(1);
      end
    end else begin
      if (!lres_r.found || (req_r.user_offset < FIELD_W'(HEADER_BYTES))) begin
        dec_word.status = STAT_NOT_LIVE;
      end else if (!prev_adj && !next_adj && (free_count_r >= FCW'(FREE_SLOTS))) begin
        dec_word.status = STAT_FULL;
      end else begin
        ldec.shift_left       = 1'b1;
        live_count_nxt        = live_count_r - LCW'(1);
        dec_word.granted_size = lres_r.hit.size;
        if (prev_adj && next_adj) begin
          fdec.load_prev  = 1'b1;
          fdec.shift_left = 1'b1;
          fdec.data.start = fres_r.prev.start;
          fdec.data.size  = fres_r.prev.size + lres_r.hit.size + fres_r.hit.size
                            + FIELD_W'(2 * HEADER_BYTES);
          free_count_nxt  = free_count_r - FCW'(1);
          dec_word.merges = 2'd2;
        end else if (prev_adj) begin
          fdec.load_prev  = 1'b1;
          fdec.data.start = fres_r.prev.start;
          fdec.data.size  = fres_r.prev.size + lres_r.hit.size + FIELD_W'(HEADER_BYTES);
          dec_word.merges = 2'd1;
        end else if (next_adj) begin
          fdec.load_hit   = 1'b1;
          fdec.data.start = hdr_f;
          fdec.data.size  = lres_r.hit.size + FIELD_W'(HEADER_BYTES) + fres_r.hit.size;
          dec_word.merges = 2'd1;
        end else begin
          fdec.shift_right = 1'b1;
          fdec.data.start  = hdr_f;
          fdec.data.size   = lres_r.hit.size;
          free_count_nxt   = free_count_r + FCW'(1);
        end
      end
    end
  end

  // updates reach the cells only when the result can be stored
  assign fcmd = apply_go ? fdec : '0;
  assign lcmd = apply_go ? ldec : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_count_r <= FCW'(1);
      live_count_r <= '0;
      launch_r     <= 1'b0;
      fdone_r      <= 1'b0;
      ldone_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (accept) begin
        fdone_r <= 1'b0;
        ldone_r <= 1'b0;
      end else begin
        if (ftok[FREE_SLOTS].live) fdone_r <= 1'b1;
        if (ltok[LIVE_SLOTS].live) ldone_r <= 1'b1;
      end
      if (apply_go) begin
        free_count_r <= free_count_nxt;
        live_count_r <= live_count_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_word;
    if (ftok[FREE_SLOTS].live) fres_r <= ftok[FREE_SLOTS];
    if (ltok[LIVE_SLOTS].live) lres_r <= ltok[LIVE_SLOTS];
    if (apply_go) out_word_r <= dec_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= FCW'(FREE_SLOTS))
    else $error("free extent count beyond table size");

  a_live_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= LCW'(LIVE_SLOTS))
    else $error("live block count beyond table size");

  a_apply_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |-> (fdone_r && ldone_r))
    else $error("update applied before both searches finished");

  a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (launch_r && (state_r == ST_SCAN)))
    else $error("accepted word did not start a search");

  a_no_stray_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !launch_r)
    else $error("search token launched while idle");
`endif

endmodule

// ===== rtl/ffaa_cell.sv =====
// one table cell: holds an entry, tests it as the search token passes, shifts on command
module ffaa_cell
  import ffaa_pkg::*;
#(
  parameter ent_t RST_ENT = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid,
  input  match_t           mode,
  input  logic [KEY_W-1:0] key,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  ent_t             left_ent,
  input  ent_t             right_ent,
  input  logic             next_before,
  output ent_t             ent,
  output logic             prev_flag,
  input  cmd_t             cmd
);

  ent_t ent_r, ent_nxt;
  tok_t tok_r, tok_nxt;
  logic hit_r, after_r, before_r;
  logic match, hit;

  // local match test against the broadcast key
  always_comb begin
    unique case (mode)
      M_FIT:   match = valid && ({1'b0, ent_r.size} >= key);
      M_ABOVE: match = !valid || ({1'b0, ent_r.start} > key);
      M_EQUAL: match = valid && ({1'b0, ent_r.start} == key);
      M_EMPTY: match = !valid;
      default: match = 1'b0;
    endcase
  end

  assign hit = !tok_in.found && match;

  // token update: first hit is captured, last valid cell ahead of it rides along
  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.hit_valid = valid;
      tok_nxt.hit       = ent_r;
    end
    if (!tok_in.found && !match && valid) begin
      tok_nxt.prev_valid = 1'b1;
      tok_nxt.prev       = ent_r;
    end
  end

  // entry update
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.shift_left && (hit_r || after_r)) begin
      ent_nxt = right_ent;
    end
    if (cmd.shift_right && after_r) begin
      ent_nxt = left_ent;
    end
    if ((cmd.shift_right || cmd.load_hit) && hit_r) begin
      ent_nxt = cmd.data;
    end
    if (cmd.load_prev && before_r && !next_before) begin
      ent_nxt = cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r    <= RST_ENT;
      tok_r    <= '0;
      hit_r    <= 1'b0;
      after_r  <= 1'b0;
      before_r <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
      tok_r <= tok_nxt;
      if (tok_in.live) begin
        hit_r    <= hit;
        after_r  <= tok_in.found;
        before_r <= !tok_in.found && !match;
      end
    end
  end

  assign tok_out   = tok_r;
  assign ent       = ent_r;
  assign prev_flag = before_r;

endmodule
